// ===== sv/dnsr_pkg.sv =====
package dnsr_pkg;

  // Packed widths of the stream payloads.
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned HeldW    = 9;

  // Protocol constants.
  localparam logic [15:0] DnsPort       = 16'd53;
  localparam logic [7:0]  UdpProto      = 8'd17;
  localparam logic [3:0]  IpVersion4    = 4'd4;
  localparam logic [16:0] MinHeaderLen  = 17'd20;
  localparam logic [16:0] UdpHeaderLen  = 17'd8;

  // Input kinds carried on tuser.
  localparam logic KindQuery    = 1'b0;
  localparam logic KindResponse = 1'b1;

  // One pending mapping in the session table.
  typedef struct packed {
    logic [31:0] server_addr;
    logic [15:0] client_port;
    logic [31:0] client_addr;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic query;
    logic search_start;
    logic search_step;
    logic fetch_last;
    logic move_last;
    logic push_result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic resp_go;
    logic hit;
    logic ptr_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/dnsr_ctrl.sv =====
module dnsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  dnsr_pkg::sts_t sts_i,
  output dnsr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FETCH,
    ST_MOVE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.is_query) begin
          cmd_o.query = 1'b1;
          state_d     = ST_EMIT;
        end else if (sts_i.resp_go) begin
          cmd_o.search_start = 1'b1;
          state_d            = ST_SEARCH;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_FETCH;
        end else if (sts_i.ptr_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch_last = 1'b1;
        state_d          = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move_last = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/dnsr_datapath.sv =====
module dnsr_datapath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [dnsr_pkg::InDataW-1:0]    in_data_i,
  input  logic                            in_kind_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [dnsr_pkg::OutDataW-1:0]   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [31:0]                     cfg_data_i,
  input  dnsr_pkg::cmd_t                  cmd_i,
  output dnsr_pkg::sts_t                  sts_o
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [31:0] redir_q;

  // Latched item.
  logic        kind_q;
  logic [3:0]  ver_q;
  logic [3:0]  words_q;
  logic [7:0]  proto_q;
  logic [15:0] total_q;
  logic [15:0] buf_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;
  logic [15:0] sport_q;
  logic [15:0] dport_q;

  // Result under construction.
  logic        applied_q;
  logic        recorded_q;
  logic [31:0] new_src_q;
  logic [31:0] new_dst_q;

  logic [CW-1:0] count_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] hit_idx_q;

  logic                          out_valid_q;
  logic [dnsr_pkg::OutDataW-1:0] out_data_q;

  dnsr_pkg::entry_t mem [TABLE_DEPTH];
  dnsr_pkg::entry_t rd_q;

  logic [16:0]      ihl, total_x, buf_x;
  logic             hdr_ok, query_hit, not_full, match, mem_we;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    last_addr, ptr_m1, rd_addr, mem_waddr;
  dnsr_pkg::entry_t mem_wdata;

  always_comb begin
    ihl     = {11'd0, words_q, 2'b00};
    total_x = {1'b0, total_q};
    buf_x   = {1'b0, buf_q};
    hdr_ok  = (redir_q != '0) &&
              (buf_x >= dnsr_pkg::MinHeaderLen) &&
              (ver_q == dnsr_pkg::IpVersion4) &&
              (ihl >= dnsr_pkg::MinHeaderLen) && (buf_x >= ihl) &&
              (proto_q == dnsr_pkg::UdpProto) &&
              (total_x <= buf_x) &&
              (total_x >= ihl + dnsr_pkg::UdpHeaderLen);
    query_hit = hdr_ok && (dport_q == dnsr_pkg::DnsPort);
    not_full  = count_q < CW'(TABLE_DEPTH);
    match     = (rd_q.client_addr == dst_q) && (rd_q.client_port == dport_q);
    cnt_m1    = count_q - CW'(1);
    last_addr = cnt_m1[AW-1:0];
    ptr_m1    = ptr_q - AW'(1);
    rd_addr   = (cmd_i.search_start || cmd_i.fetch_last) ? last_addr : ptr_m1;
    mem_we    = (cmd_i.query && query_hit && not_full) || cmd_i.move_last;
    mem_waddr = cmd_i.move_last ? hit_idx_q : count_q[AW-1:0];
    if (cmd_i.move_last) begin
      mem_wdata = rd_q;
    end else begin
      mem_wdata.server_addr = dst_q;
      mem_wdata.client_port = sport_q;
      mem_wdata.client_addr = src_q;
    end
  end

  always_comb begin
    sts_o.is_query = (kind_q == dnsr_pkg::KindQuery);
    sts_o.resp_go  = (kind_q == dnsr_pkg::KindResponse) && hdr_ok &&
                     (sport_q == dnsr_pkg::DnsPort) && (src_q == redir_q) &&
                     (count_q != '0);
    sts_o.hit      = match;
    sts_o.ptr_zero = (ptr_q == '0);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Session table: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= in_kind_i;
      ver_q      <= in_data_i[3:0];
      words_q    <= in_data_i[7:4];
      proto_q    <= in_data_i[15:8];
      total_q    <= in_data_i[31:16];
      buf_q      <= in_data_i[47:32];
      src_q      <= in_data_i[79:48];
      dst_q      <= in_data_i[111:80];
      sport_q    <= in_data_i[127:112];
      dport_q    <= in_data_i[143:128];
      applied_q  <= 1'b0;
      recorded_q <= 1'b0;
      new_src_q  <= in_data_i[79:48];
      new_dst_q  <= in_data_i[111:80];
    end
    if (cmd_i.query && query_hit) begin
      applied_q  <= 1'b1;
      new_dst_q  <= redir_q;
      recorded_q <= not_full;
    end
    if (cmd_i.search_start) begin
      ptr_q <= last_addr;
    end
    if (cmd_i.search_step) begin
      if (match) begin
        new_src_q <= rd_q.server_addr;
        hit_idx_q <= ptr_q;
      end else begin
        ptr_q <= ptr_m1;
      end
    end
    if (cmd_i.move_last) begin
      applied_q <= 1'b1;
    end
    if (cmd_i.push_result) begin
      out_data_q <= {5'd0, dnsr_pkg::HeldW'(count_q), recorded_q, new_dst_q,
                     new_src_q, applied_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      redir_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        redir_q <= cfg_data_i;
      end
      if (cmd_i.query && query_hit && not_full) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.move_last) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.push_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/dns_redirect_nat_table_unit.sv =====
// DNS redirect session table.
// The input stream carries one beat per packet: parsed IPv4/UDP header fields
// on s_axis_tdata and the packet kind on s_axis_tuser (0 = outgoing query,
// 1 = incoming response). Each input beat produces exactly one output beat on
// m_axis with the rewritten addresses, the applied and recorded flags, and
// the number of pending mappings after that packet.
// The redirect address is written through the cfg channel, which is always
// ready; it should only be written while the block is idle.
// A query is checked in ST_CHECK after its beat is accepted and then goes to
// the output register from ST_EMIT once that register is free, after which
// the block returns to idle to take the next beat. A response walks the table
// newest-first, one entry per cycle, and on a hit first copies the last entry
// into the freed slot (ST_FETCH, then ST_MOVE) before its result is pushed.
// The block works on one packet at a time; s_axis_tready is high only while
// it waits for a packet. A finished result sits in the output register, so the
// next packet is accepted while the receiver stalls; the block only waits if
// a second result is ready before the first one has been taken.
// Reset empties the table (the count goes to zero, no clearing pass is needed
// since only entries below the count are read) and clears the redirect
// address, which disables all rewriting until it is written.
module dns_redirect_nat_table_unit #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input beat.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] ip_version, [7:4] header_words, [15:8] protocol_number,
  // [31:16] total_length, [47:32] buffer_length, [79:48] source_address,
  // [111:80] dest_address, [127:112] source_port, [143:128] dest_port
  input  logic [dnsr_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  // Result beat.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] applied, [32:1] new_source_address, [64:33] new_dest_address,
  // [65] recorded, [74:66] entries_held, [79:75] zero
  output logic [dnsr_pkg::OutDataW-1:0] m_axis_tdata,
  // Redirect address write.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i
);

  dnsr_pkg::cmd_t cmd;
  dnsr_pkg::sts_t sts;

  // The sequencer decides what happens each cycle; the datapath holds the
  // packet, the table and the result register.
  dnsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dnsr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_kind_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign s_axis_tready = cmd.in_ready;
  assign cfg_ready_o   = 1'b1;

  // A result is only pushed when the output register can take it.
  a_push_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_result |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result pushed over a stalled output beat");

  // After an accept the block is busy with that packet.
  a_busy_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // The sequencer issues at most one datapath command per cycle.
  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.query, cmd.search_start, cmd.search_step,
              cmd.fetch_last, cmd.move_last, cmd.push_result}))
    else $error("more than one datapath command in a cycle");

  // A table hit is always followed by fetching the last entry.
  a_hit_fetch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.search_step && sts.hit) |=> cmd.fetch_last)
    else $error("hit not followed by the last-entry fetch");

endmodule

// ===== sim/dns_redirect_nat_table_unit_test.sv =====
module dns_redirect_nat_table_unit_test;
  import dnsr_pkg::*;

  localparam int unsigned NatDepth     = 256;
  localparam int unsigned IdlePct      = 35;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned SettleCycles = 8;

  // One parsed packet header as it travels on the input stream.
  typedef struct packed {
    logic        kind;
    logic [3:0]  ver;
    logic [3:0]  hw;
    logic [7:0]  proto;
    logic [15:0] ip_total;
    logic [15:0] buf_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
  } packet_t;

  // One result beat, unpacked.
  typedef struct packed {
    logic             applied;
    logic [31:0]      new_src;
    logic [31:0]      new_dst;
    logic             recorded;
    logic [HeldW-1:0] held;
    logic [4:0]       pad;
  } rewrite_t;

  // Ways to spoil an otherwise good header.
  typedef enum int unsigned {
    FaultVersion,
    FaultShortHeader,
    FaultHeaderPastBuffer,
    FaultProtocol,
    FaultTotalPastBuffer,
    FaultTotalShort,
    FaultShortBuffer,
    FaultPort,
    FaultSource
  } fault_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [31:0]         cfg_data_i    = '0;

  // Shadow copy of the session table and the redirect register.
  logic [31:0]      redirect_model = '0;
  logic [31:0]      nat_client_addr [NatDepth];
  logic [15:0]      nat_client_port [NatDepth];
  logic [31:0]      nat_server_addr [NatDepth];
  logic [HeldW-1:0] nat_count = '0;

  rewrite_t    rewrites_due [$];
  int unsigned fault_count = 0;
  // When set, neither side of the stream inserts idle cycles.
  logic        steady = 1'b0;

  dns_redirect_nat_table_unit #(
    .TABLE_DEPTH(NatDepth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Computes the rewrite for one accepted packet and updates the shadow table.
  function automatic rewrite_t predict_rewrite(input packet_t p);
    rewrite_t         r;
    int unsigned      ihl;
    logic             hdr_ok;
    logic             found;
    logic [HeldW-1:0] last;
    r.applied  = 1'b0;
    r.new_src  = p.src_addr;
    r.new_dst  = p.dst_addr;
    r.recorded = 1'b0;
    r.pad      = '0;
    ihl = p.hw * 4;
    hdr_ok = (redirect_model != 0) && (p.buf_len >= MinHeaderLen) &&
             (p.ver == IpVersion4) && (ihl >= MinHeaderLen) && (ihl <= p.buf_len) &&
             (p.proto == UdpProto) && (p.ip_total <= p.buf_len) &&
             (p.ip_total >= ihl + UdpHeaderLen);
    if (hdr_ok && p.kind == KindQuery) begin
      if (p.udp_dport == DnsPort) begin
        // A full table still redirects, it just cannot remember the client.
        if (nat_count < NatDepth) begin
          nat_client_addr[nat_count] = p.src_addr;
          nat_client_port[nat_count] = p.udp_sport;
          nat_server_addr[nat_count] = p.dst_addr;
          nat_count  = nat_count + 1'b1;
          r.recorded = 1'b1;
        end
        r.new_dst = redirect_model;
        r.applied = 1'b1;
      end
    end else if (hdr_ok && p.udp_sport == DnsPort && p.src_addr == redirect_model) begin
      // Newest entry wins; the hole is filled with the last entry.
      found = 1'b0;
      for (int k = int'(nat_count) - 1; k >= 0 && !found; k--) begin
        if (nat_client_addr[k] == p.dst_addr && nat_client_port[k] == p.udp_dport) begin
          found = 1'b1;
          last  = nat_count - 1'b1;
          r.new_src = nat_server_addr[k];
          nat_client_addr[k] = nat_client_addr[last];
          nat_client_port[k] = nat_client_port[last];
          nat_server_addr[k] = nat_server_addr[last];
          nat_count = last;
          r.applied = 1'b1;
        end
      end
    end
    r.held = nat_count;
    return r;
  endfunction

  // Drives one packet and waits for its beat to be taken. Valid is left high
  // after the beat so that a following packet can go out back to back.
  task automatic send_packet(input packet_t p);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.kind;
    s_axis_tdata  <= {p.udp_dport, p.udp_sport, p.dst_addr, p.src_addr,
                      p.buf_len, p.ip_total, p.proto, p.hw, p.ver};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rewrites_due.push_back(predict_rewrite(p));
  endtask

  // Stops the input stream and waits until every result has come back.
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (rewrites_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_redirect(input logic [31:0] value);
    await_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    redirect_model = value;
    @(posedge clk_i);
  endtask

  task automatic check_result(input logic [OutDataW-1:0] d);
    rewrite_t got;
    rewrite_t want;
    got.applied  = d[0];
    got.new_src  = d[32:1];
    got.new_dst  = d[64:33];
    got.recorded = d[65];
    got.held     = d[74:66];
    got.pad      = d[79:75];
    if (rewrites_due.size() == 0) begin
      if (fault_count < MaxReports) $display("Unexpected result beat %h", d);
      fault_count++;
    end else begin
      want = rewrites_due.pop_front();
      if (got !== want) begin
        if (fault_count < MaxReports) begin
          $display("Mismatch: expected applied=%0b src=%h dst=%h recorded=%0b held=%0d pad=%h",
                   want.applied, want.new_src, want.new_dst, want.recorded, want.held,
                   want.pad);
          $display("          actual   applied=%0b src=%h dst=%h recorded=%0b held=%0d pad=%h",
                   got.applied, got.new_src, got.new_dst, got.recorded, got.held, got.pad);
        end
        fault_count++;
      end
    end
  endtask

  // Result side: check every beat taken, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // A well-formed UDP header with a fixed shape and the given endpoints.
  function automatic packet_t udp_packet(input logic kind, input logic [31:0] src,
                                         input logic [31:0] dst, input logic [15:0] sport,
                                         input logic [15:0] dport);
    packet_t p;
    p.kind      = kind;
    p.ver       = IpVersion4;
    p.hw        = 4'd5;
    p.proto     = UdpProto;
    p.ip_total  = 16'd60;
    p.buf_len   = 16'd80;
    p.src_addr  = src;
    p.dst_addr  = dst;
    p.udp_sport = sport;
    p.udp_dport = dport;
    return p;
  endfunction

  // A header that passes every check, with random lengths and endpoints.
  function automatic packet_t good_header(input logic kind);
    packet_t     p;
    int unsigned ihl;
    p.kind  = kind;
    p.ver   = IpVersion4;
    p.hw    = 4'($urandom_range(15, 5));
    p.proto = UdpProto;
    ihl = p.hw * 4;
    // Mostly short packets, sometimes anything up to the largest buffer.
    p.buf_len   = 16'($urandom_range(($urandom_range(3) == 0) ? 65535 : ihl + 600, ihl + 8));
    p.ip_total  = 16'($urandom_range(p.buf_len, ihl + 8));
    p.src_addr  = $urandom;
    p.dst_addr  = $urandom;
    p.udp_sport = 16'($urandom);
    p.udp_dport = 16'($urandom);
    return p;
  endfunction

  // Spoils exactly one aspect of a good header so that it must be ignored.
  function automatic packet_t inject_fault(input packet_t p);
    packet_t     q;
    int unsigned ihl;
    fault_e      f;
    q = p;
    ihl = q.hw * 4;
    f = fault_e'($urandom_range(int'(FaultSource)));
    case (f)
      FaultVersion: q.ver = IpVersion4 ^ 4'($urandom_range(15, 1));
      FaultShortHeader: q.hw = 4'($urandom_range(4));
      FaultHeaderPastBuffer: begin
        q.hw       = 4'd15;
        q.buf_len  = 16'($urandom_range(59, 20));
        q.ip_total = 16'($urandom_range(q.buf_len));
      end
      FaultProtocol: q.proto = UdpProto ^ 8'($urandom_range(255, 1));
      FaultTotalPastBuffer: begin
        q.buf_len  = 16'($urandom_range(65534, ihl + 8));
        q.ip_total = 16'($urandom_range(65535, q.buf_len + 1));
      end
      FaultTotalShort: q.ip_total = 16'($urandom_range(ihl + 7));
      FaultShortBuffer: q.buf_len = 16'($urandom_range(19));
      FaultPort: begin
        if (q.kind == KindQuery) q.udp_dport = DnsPort ^ 16'($urandom_range(65535, 1));
        else q.udp_sport = DnsPort ^ 16'($urandom_range(65535, 1));
      end
      default: begin
        if (q.kind == KindResponse) begin
          q.src_addr = redirect_model ^ 32'($urandom_range(32'hFFFF_FFFF, 1));
        end else begin
          q.udp_dport = DnsPort ^ 16'($urandom_range(65535, 1));
        end
      end
    endcase
    return q;
  endfunction

  // Mostly well-formed query/response traffic from a small client pool so
  // that responses find their entries, plus broken headers and raw noise.
  function automatic packet_t random_packet();
    packet_t     p;
    int unsigned pick;
    int unsigned slot;
    logic        is_query;
    pick = $urandom_range(99);
    if (pick < 8) begin
      p.kind      = 1'($urandom);
      p.ver       = 4'($urandom);
      p.hw        = 4'($urandom);
      p.proto     = 8'($urandom);
      p.ip_total  = 16'($urandom);
      p.buf_len   = 16'($urandom);
      p.src_addr  = $urandom;
      p.dst_addr  = $urandom;
      p.udp_sport = 16'($urandom);
      p.udp_dport = 16'($urandom);
    end else begin
      is_query = $urandom_range(99) < ((nat_count < 32) ? 60 : 30);
      p = good_header(is_query ? KindQuery : KindResponse);
      if (is_query) begin
        p.src_addr = {24'h0A0000, 8'($urandom_range(15))};
        if ($urandom_range(3) != 0) p.udp_sport = 16'($urandom_range(1027, 1024));
        p.udp_dport = DnsPort;
      end else begin
        p.src_addr  = redirect_model;
        p.udp_sport = DnsPort;
        // Usually answer a live client; otherwise the random endpoint misses.
        if (nat_count != 0 && $urandom_range(9) != 0) begin
          slot = $urandom_range(nat_count - 1);
          p.dst_addr  = nat_client_addr[slot];
          p.udp_dport = nat_client_port[slot];
        end
      end
      if (pick < 20) p = inject_fault(p);
    end
    return p;
  endfunction

  // With the register still at its reset value nothing may be rewritten.
  task automatic test_rewrite_disabled();
    send_packet(udp_packet(KindQuery, 32'h0A00_0001, 32'h0808_0808, 16'd1234, DnsPort));
    send_packet(udp_packet(KindResponse, 32'h0, 32'h0A00_0001, DnsPort, 16'd1234));
    send_packet(udp_packet(KindResponse, 32'h0808_0808, 32'h0A00_0001, DnsPort, 16'd1234));
  endtask

  // Each header check is made to fail once, plus the smallest legal header.
  task automatic test_header_checks();
    packet_t base;
    packet_t p;
    write_redirect(32'hC0A8_0001);
    base = udp_packet(KindQuery, 32'h0A00_0001, 32'h0808_0404, 16'd3000, DnsPort);
    send_packet(base);
    p = base; p.ver = 4'd6;                                 send_packet(p);
    p = base; p.hw = 4'd4;                                  send_packet(p);
    p = base; p.hw = 4'd15; p.buf_len = 16'd40; p.ip_total = 16'd40;
    send_packet(p);
    p = base; p.proto = 8'd6;                               send_packet(p);
    p = base; p.ip_total = p.buf_len + 16'd1;               send_packet(p);
    p = base; p.ip_total = 16'd27;                          send_packet(p);
    p = base; p.buf_len = 16'd19; p.ip_total = 16'd19;      send_packet(p);
    p = base; p.udp_dport = DnsPort + 16'd1;                send_packet(p);
    // Exactly the minimum: 20-byte header, 8-byte UDP header, nothing spare.
    p = base; p.ip_total = 16'd28; p.buf_len = 16'd28;      send_packet(p);
  endtask

  // Matching order, duplicate mappings, misses and rejected responses.
  task automatic test_response_match();
    send_packet(udp_packet(KindQuery, 32'h0A00_0005, 32'h0808_0808, 16'd4000, DnsPort));
    send_packet(udp_packet(KindQuery, 32'h0A00_0005, 32'h0101_0101, 16'd4000, DnsPort));
    send_packet(udp_packet(KindQuery, 32'h0A00_0006, 32'h0909_0909, 16'd5000, DnsPort));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0001, 32'h0A00_0005, DnsPort, 16'd4000));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0001, 32'h0A00_0005, 16'd5353, 16'd4000));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0000, 32'h0A00_0005, DnsPort, 16'd4000));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0001, 32'h0A00_0005, DnsPort, 16'd4000));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0001, 32'h0A00_0005, DnsPort, 16'd4000));
    send_packet(udp_packet(KindResponse, 32'hC0A8_0001, 32'h0A00_0006, DnsPort, 16'd5000));
  endtask

  task automatic test_field_extremes();
    packet_t p;
    p = '0;                                        send_packet(p);
    p = '0; p.kind = KindResponse;                 send_packet(p);
    p = '1; p.kind = KindQuery;                    send_packet(p);
    p = '1;                                        send_packet(p);
    // Largest legal header with all-ones endpoints, then its answer.
    p = '1; p.kind = KindQuery; p.ver = IpVersion4; p.proto = UdpProto; p.udp_dport = DnsPort;
    send_packet(p);
    p.kind      = KindResponse;
    p.src_addr  = redirect_model;
    p.udp_sport = DnsPort;
    p.udp_dport = 16'hFFFF;
    send_packet(p);
  endtask

  // Fill the table, overflow it, then empty it with answers in random order.
  task automatic test_table_full();
    int unsigned slot;
    write_redirect(32'hFFFF_FFFF);
    for (int unsigned i = 0; i < NatDepth + 3; i++) begin
      send_packet(udp_packet(KindQuery, 32'h0A01_0000 + i, $urandom, 16'($urandom), DnsPort));
    end
    while (nat_count != 0) begin
      slot = $urandom_range(nat_count - 1);
      send_packet(udp_packet(KindResponse, redirect_model, nat_client_addr[slot], DnsPort,
                             nat_client_port[slot]));
    end
  endtask

  // Random traffic in phases, each with its own redirect address. The second
  // phase runs both stream sides without any idle cycles.
  task automatic test_random_traffic();
    logic [31:0] targets [5];
    int unsigned counts [5];
    targets = '{$urandom, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, $urandom};
    counts  = '{160, 160, 140, 40, 160};
    for (int ph = 0; ph < 5; ph++) begin
      write_redirect(targets[ph]);
      steady = (ph == 1);
      repeat (counts[ph]) send_packet(random_packet());
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rewrite_disabled();
    test_header_checks();
    test_response_match();
    test_field_extremes();
    test_table_full();
    test_random_traffic();
    await_idle();
    if (fault_count == 0 && rewrites_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
